>>> hw/rtl/s2c_pkg.sv
// ----------------------------------------------------------------------------
// s2c_pkg
// Shared types and fixed-point constants of the spherical to cartesian block.
// ----------------------------------------------------------------------------
`default_nettype none

package s2c_pkg;

  // angle in 1/64 degree
  localparam logic [14:0] TURN_A    = 15'd23040;
  localparam logic [14:0] QUART_A   = 15'd5760;
  localparam logic [14:0] HALF_A    = 15'd11520;
  localparam logic [14:0] THREEQ_A  = 15'd17280;
  localparam logic [12:0] OCTANT_A  = 13'd2880;

  // radians in q30: x = t*X_INT + floor((t*X_FRAC + X_BIAS) / 46080)
  localparam logic [18:0] X_INT     = 19'd292817;
  localparam logic [14:0] X_FRAC    = 15'd30345;
  localparam logic [26:0] X_BIAS    = 27'd23040;
  // floor(m / 45) = (m * RCP45) >> 28 for m below 2^17
  localparam logic [22:0] RCP45     = 23'd5965233;

  // floor(m / k) = (m * RCPk) >> 34 for m below 2^29
  localparam logic [32:0] RCP3      = 33'd5726623062;
  localparam logic [32:0] RCP5      = 33'd3435973837;
  localparam logic [32:0] RCP7      = 33'd2454267027;
  localparam logic [32:0] RCP15     = 33'd1145324613;
  localparam logic [32:0] RCP21     = 33'd818089009;

  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;

  localparam int unsigned TRIG_LAT  = 11;
  localparam int unsigned MIX_LAT   = 3;

  // reduced angle: position in the quarter turn and sign of the result
  typedef struct packed {
    logic [12:0] t;
    logic        neg;
  } ang_t;

endpackage

`default_nettype wire

>>> hw/rtl/s2c_trig.sv
// ----------------------------------------------------------------------------
// s2c_trig
// Pipelined fixed-point sine of a reduced angle, q16 result with sign.
// ----------------------------------------------------------------------------
`default_nettype none

module s2c_trig import s2c_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  ang_t               ang_in,
  output logic signed [17:0] val
);

  logic        use_cos;
  logic [11:0] tt;
  logic [29:0] a2_nxt;
  logic [26:0] b2_nxt;
  logic        cos2_r, neg2_r;
  logic [29:0] a2_r;
  logic [26:0] b2_r;

  logic [39:0] prod3;
  logic        cos3_r, neg3_r;
  logic [29:0] a3_r;
  logic [10:0] q3_r;

  logic        cos4_r, neg4_r;
  logic [29:0] x4_r;

  logic [59:0] sq5;
  logic        cos5_r, neg5_r;
  logic [29:0] x5_r, x25_r;

  logic [28:0] m6;
  logic [32:0] c6;
  logic [61:0] p6;
  logic        cos6_r, neg6_r;
  logic [29:0] x6_r, x26_r;
  logic [30:0] s6_r;

  logic [60:0] p7;
  logic        cos7_r, neg7_r;
  logic [29:0] x7_r, x27_r, p7_r;

  logic [28:0] m8;
  logic [32:0] c8;
  logic [61:0] p8;
  logic        cos8_r, neg8_r;
  logic [29:0] x8_r, x28_r;
  logic [30:0] s8_r;

  logic [60:0] p9;
  logic        cos9_r, neg9_r;
  logic [29:0] x9_r, x29_r, p9_r;

  logic [28:0] m10;
  logic [61:0] p10;
  logic        cos10_r, neg10_r;
  logic [29:0] x10_r, x210_r;
  logic [30:0] s10_r;

  logic [29:0] op11;
  logic [60:0] p11;
  logic        cos11_r, neg11_r;
  logic [29:0] p11_r;

  logic [30:0] v12;
  logic [30:0] vr12;
  logic [16:0] mag12;
  logic signed [17:0] val_r;

  // beyond 45 degrees the cosine series runs on the complement
  assign use_cos = ang_in.t > OCTANT_A;
  assign tt      = use_cos ? 12'(13'(QUART_A) - ang_in.t) : ang_in.t[11:0];
  assign a2_nxt  = 30'(tt) * 30'(X_INT);
  assign b2_nxt  = 27'(tt) * 27'(X_FRAC) + X_BIAS;

  assign prod3 = 40'(b2_r[26:10]) * 40'(RCP45);

  assign sq5 = 60'(x4_r) * 60'(x4_r) + 60'(31'h2000_0000);

  assign m6 = cos5_r ? 29'(x25_r[29:3]) : x25_r[29:1];
  assign c6 = cos5_r ? RCP7 : RCP21;
  assign p6 = 62'(m6) * 62'(c6);

  assign p7 = 61'(x26_r) * 61'(s6_r);

  assign m8 = cos7_r ? p7_r[29:1] : 29'(p7_r[29:2]);
  assign c8 = cos7_r ? RCP15 : RCP5;
  assign p8 = 62'(m8) * 62'(c8);

  assign p9 = 61'(x28_r) * 61'(s8_r);

  assign m10 = cos9_r ? 29'(p9_r[29:2]) : p9_r[29:1];
  assign p10 = 62'(m10) * 62'(RCP3);

  assign op11 = cos10_r ? x210_r : x10_r;
  assign p11  = 61'(op11) * 61'(s10_r);

  assign v12   = cos11_r ? (Q30_ONE - 31'(p11_r[29:1])) : 31'(p11_r);
  assign vr12  = v12 + 31'h2000;
  assign mag12 = vr12[30:14];

  always_ff @(posedge clk) begin
    if (en) begin
      cos2_r  <= use_cos;       neg2_r  <= ang_in.neg;
      a2_r    <= a2_nxt;        b2_r    <= b2_nxt;

      cos3_r  <= cos2_r;        neg3_r  <= neg2_r;
      a3_r    <= a2_r;          q3_r    <= prod3[38:28];

      cos4_r  <= cos3_r;        neg4_r  <= neg3_r;
      x4_r    <= a3_r + 30'(q3_r);

      cos5_r  <= cos4_r;        neg5_r  <= neg4_r;
      x5_r    <= x4_r;          x25_r   <= sq5[59:30];

      cos6_r  <= cos5_r;        neg6_r  <= neg5_r;
      x6_r    <= x5_r;          x26_r   <= x25_r;
      s6_r    <= Q30_ONE - 31'(p6[61:34]);

      cos7_r  <= cos6_r;        neg7_r  <= neg6_r;
      x7_r    <= x6_r;          x27_r   <= x26_r;
      p7_r    <= p7[59:30];

      cos8_r  <= cos7_r;        neg8_r  <= neg7_r;
      x8_r    <= x7_r;          x28_r   <= x27_r;
      s8_r    <= Q30_ONE - 31'(p8[61:34]);

      cos9_r  <= cos8_r;        neg9_r  <= neg8_r;
      x9_r    <= x8_r;          x29_r   <= x28_r;
      p9_r    <= p9[59:30];

      cos10_r <= cos9_r;        neg10_r <= neg9_r;
      x10_r   <= x9_r;          x210_r  <= x29_r;
      s10_r   <= Q30_ONE - 31'(p10[61:34]);

      cos11_r <= cos10_r;       neg11_r <= neg10_r;
      p11_r   <= p11[59:30];

      val_r   <= neg11_r ? -$signed(18'(mag12)) : $signed(18'(mag12));
    end
  end

  assign val = val_r;

endmodule

`default_nettype wire

>>> hw/rtl/s2c_mix.sv
// ----------------------------------------------------------------------------
// s2c_mix
// Scales the trig products by the range and rounds to q8.8 coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module s2c_mix import s2c_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        rng,
  input  logic signed [17:0] sp,
  input  logic signed [17:0] cp,
  input  logic signed [17:0] sa,
  input  logic signed [17:0] ca,
  output logic signed [16:0] x_pos,
  output logic signed [16:0] y_pos,
  output logic signed [16:0] z_pos
);

  logic signed [35:0] px1_r, py1_r;
  logic signed [17:0] cp1_r;
  logic [15:0]        rng1_r;

  logic [35:0] ax2, ay2;
  logic [17:0] az2;
  logic [48:0] rx2_r, ry2_r;
  logic [32:0] rz2_r;
  logic        nx2_r, ny2_r, nz2_r;

  logic [48:0] sx3, sy3;
  logic [32:0] sz3;
  logic [16:0] qx3, qy3, qz3;

  logic signed [16:0] x_r, y_r, z_r;

  assign ax2 = px1_r[35] ? 36'(-px1_r) : 36'(px1_r);
  assign ay2 = py1_r[35] ? 36'(-py1_r) : 36'(py1_r);
  assign az2 = cp1_r[17] ? 18'(-cp1_r) : 18'(cp1_r);

  // round half away from zero on the magnitude
  assign sx3 = rx2_r + 49'h0_8000_0000;
  assign sy3 = ry2_r + 49'h0_8000_0000;
  assign sz3 = rz2_r + 33'h8000;
  assign qx3 = sx3[48:32];
  assign qy3 = sy3[48:32];
  assign qz3 = sz3[32:16];

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r  <= sp * ca;
      py1_r  <= sp * sa;
      cp1_r  <= cp;
      rng1_r <= rng;

      rx2_r  <= 49'(rng1_r) * 49'(ax2[32:0]);
      ry2_r  <= 49'(rng1_r) * 49'(ay2[32:0]);
      rz2_r  <= 33'(rng1_r) * 33'(az2[16:0]);
      nx2_r  <= px1_r[35];
      ny2_r  <= py1_r[35];
      nz2_r  <= cp1_r[17];

      x_r    <= nx2_r ? -$signed(qx3) : $signed(qx3);
      y_r    <= ny2_r ? -$signed(qy3) : $signed(qy3);
      z_r    <= nz2_r ? -$signed(qz3) : $signed(qz3);
    end
  end

  assign x_pos = x_r;
  assign y_pos = y_r;
  assign z_pos = z_r;

endmodule

`default_nettype wire

>>> hw/rtl/spherical_to_cartesian.sv
// ----------------------------------------------------------------------------
// spherical_to_cartesian
// Converts radar detections (range, elevation, azimuth) to x, y, z points.
// ----------------------------------------------------------------------------
// Input beats carry range (q8.8 m), elevation and azimuth (1/64 degree) and a
// frame-end mark; output beats carry x, y, z (q8.8 m, rounded) and the mark.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low.
// One beat is taken every cycle while in_stall is low. The depth is set by
// the sine series: one angle reduction stage feeds four angle evaluators
// running side by side, each eleven registered stages deep, followed by
// three scaling stages.
// Reset clears all valid bits; the pipeline is empty afterwards and data
// registers keep whatever they held.
// While the output holds a beat and the receiver stalls, the whole pipeline
// freezes and in_stall is raised in the same cycle; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module spherical_to_cartesian import s2c_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_range_q8,
  input  logic signed [13:0] in_elevation,
  input  logic signed [14:0] in_azimuth,
  input  logic               in_last_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] out_x_pos,
  output logic signed [16:0] out_y_pos,
  output logic signed [16:0] out_z_pos,
  output logic               out_last_out
);

  localparam int unsigned RNG_LAT = 1 + TRIG_LAT;
  localparam int unsigned LAT     = RNG_LAT + MIX_LAT;

  logic               en;
  logic [LAT-1:0]     valid_r, last_r;
  logic [15:0]        rng_r [RNG_LAT];
  logic signed [16:0] polar, polar_c, az, az_c;
  ang_t               sp_ang_r, cp_ang_r, sa_ang_r, ca_ang_r;
  logic signed [17:0] sp_w, cp_w, sa_w, ca_w;

  // fold an angle into the first quarter turn and record the sign
  function automatic ang_t prep(input logic signed [16:0] a);
    logic [14:0] u;
    logic [14:0] tq;
    logic [1:0]  q;
    ang_t        r;
    if (a < 0) u = 15'(a + 17'sd23040);
    else       u = a[14:0];
    if (u >= THREEQ_A) begin
      q  = 2'd3;
      tq = u - THREEQ_A;
    end else if (u >= HALF_A) begin
      q  = 2'd2;
      tq = u - HALF_A;
    end else if (u >= QUART_A) begin
      q  = 2'd1;
      tq = u - QUART_A;
    end else begin
      q  = 2'd0;
      tq = u;
    end
    r.t   = q[0] ? 13'(QUART_A - tq) : tq[12:0];
    r.neg = q[1];
    return r;
  endfunction

  assign en       = !valid_r[LAT-1] || !out_stall;
  assign in_stall = !en;

  assign polar   = 17'sd5760 - 17'(in_elevation);
  assign polar_c = polar + 17'sd5760;
  assign az      = 17'(in_azimuth);
  assign az_c    = az + 17'sd5760;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_r   <= {last_r[LAT-2:0], in_last_in};
      rng_r[0] <= in_range_q8;
      for (int i = 1; i < RNG_LAT; i++) rng_r[i] <= rng_r[i-1];
      sp_ang_r <= prep(polar);
      cp_ang_r <= prep(polar_c);
      sa_ang_r <= prep(az);
      ca_ang_r <= prep(az_c);
    end
  end

  s2c_trig u_trig_sp (.clk(clk), .en(en), .ang_in(sp_ang_r), .val(sp_w));
  s2c_trig u_trig_cp (.clk(clk), .en(en), .ang_in(cp_ang_r), .val(cp_w));
  s2c_trig u_trig_sa (.clk(clk), .en(en), .ang_in(sa_ang_r), .val(sa_w));
  s2c_trig u_trig_ca (.clk(clk), .en(en), .ang_in(ca_ang_r), .val(ca_w));

  s2c_mix u_mix (
    .clk  (clk),
    .en   (en),
    .rng  (rng_r[RNG_LAT-1]),
    .sp   (sp_w),
    .cp   (cp_w),
    .sa   (sa_w),
    .ca   (ca_w),
    .x_pos(out_x_pos),
    .y_pos(out_y_pos),
    .z_pos(out_z_pos)
  );

  assign out_valid    = valid_r[LAT-1];
  assign out_last_out = last_r[LAT-1];

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> valid_r[0])
    else $error("accepted beat missing in first stage");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_trig_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[RNG_LAT-1] |-> (sp_w <= 18'sd65536) && (sp_w >= -18'sd65536)
                        && (ca_w <= 18'sd65536) && (ca_w >= -18'sd65536))
    else $error("trig value beyond unit magnitude");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_x_pos != 17'sh10000) && (out_y_pos != 17'sh10000)
               && (out_z_pos != 17'sh10000))
    else $error("coordinate beyond range magnitude");

endmodule

`default_nettype wire

>>> tb/s2c_point_checker.sv
// ----------------------------------------------------------------------------
// s2c_point_checker
// Watches both channels of the spherical to cartesian block, computes the
// expected fixed-point x, y, z point of every accepted detection and compares
// each output beat against the oldest expected point.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module s2c_point_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [15:0]        in_range_q8,
  input  logic signed [13:0] in_elevation,
  input  logic signed [14:0] in_azimuth,
  input  logic               in_last_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [16:0] out_x_pos,
  input  logic signed [16:0] out_y_pos,
  input  logic signed [16:0] out_z_pos,
  input  logic               out_last_out,
  output int                 errors,
  output int                 pending
);

  localparam int DEG_TURN = 23040;
  localparam int DEG_QUART = 5760;
  localparam longint unsigned PI_Q32 = 64'd13493037705;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef struct {
    logic [16:0] x;
    logic [16:0] y;
    logic [16:0] z;
    logic        last;
  } point_t;

  point_t exp_points[$];

  function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // sine over one quarter turn, q16 magnitude
  function automatic longint unsigned quarter_sine(int t_in);
    int t;
    bit from_cos;
    longint unsigned rad, rad2, acc, v;
    t = t_in;
    from_cos = 0;
    if (t > DEG_QUART) t = DEG_QUART;
    if (t > DEG_QUART / 2) begin
      t = DEG_QUART - t;
      from_cos = 1;
    end
    rad = (longint'(t) * PI_Q32 + 64'd23040) / 64'd46080;
    rad2 = (rad * rad + (64'd1 << 29)) >> 30;
    if (from_cos) begin
      acc = ONE_Q30 - rad2 / 56;
      acc = ONE_Q30 - mul_q30(rad2, acc) / 30;
      acc = ONE_Q30 - mul_q30(rad2, acc) / 12;
      v = ONE_Q30 - mul_q30(rad2, acc) / 2;
    end else begin
      acc = ONE_Q30 - rad2 / 42;
      acc = ONE_Q30 - mul_q30(rad2, acc) / 20;
      acc = ONE_Q30 - mul_q30(rad2, acc) / 6;
      v = mul_q30(rad, acc);
    end
    return (v + (64'd1 << 13)) >> 14;
  endfunction

  function automatic longint sine_q16(int a);
    int u, quad, t;
    longint m;
    u = (a % DEG_TURN + DEG_TURN) % DEG_TURN;
    quad = u / DEG_QUART;
    t = u % DEG_QUART;
    if (quad == 0 || quad == 2) m = longint'(quarter_sine(t));
    else m = longint'(quarter_sine(DEG_QUART - t));
    return (quad >= 2) ? -m : m;
  endfunction

  function automatic longint cosine_q16(int a);
    return sine_q16((a % DEG_TURN) + DEG_QUART);
  endfunction

  // r * p / 2^sh, rounded half away from zero, kept to 17 bits
  function automatic logic [16:0] scale_coord(longint unsigned r, longint p, int sh);
    longint unsigned mag, q;
    mag = (p < 0) ? longint'(-p) : longint'(p);
    q = (r * mag + (64'd1 << (sh - 1))) >> sh;
    return (p < 0) ? 17'(64'd0 - q) : 17'(q);
  endfunction

  function automatic point_t predict_point(logic [15:0] rng, logic signed [13:0] elev,
                                           logic signed [14:0] azim, logic last);
    point_t pt;
    int polar;
    longint sp, cp, sa, ca;
    polar = DEG_QUART - int'(elev);
    sp = sine_q16(polar);
    cp = cosine_q16(polar);
    sa = sine_q16(int'(azim));
    ca = cosine_q16(int'(azim));
    pt.x = scale_coord(longint'(rng), sp * ca, 32);
    pt.y = scale_coord(longint'(rng), sp * sa, 32);
    pt.z = scale_coord(longint'(rng), cp, 16);
    pt.last = last;
    return pt;
  endfunction

  task automatic report_mismatch(string field, logic [16:0] got, logic [16:0] want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, field,
             $signed(got), $signed(want));
    errors++;
  endtask

  initial errors = 0;
  assign pending = exp_points.size();

  always @(posedge clk) begin
    point_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        exp_points.push_back(predict_point(in_range_q8, in_elevation, in_azimuth,
                                           in_last_in));
      if (out_valid && !out_stall) begin
        if (exp_points.size() == 0) begin
          $display("%0t output beat with no detection outstanding", $time);
          errors++;
        end else begin
          want = exp_points.pop_front();
          if (out_x_pos !== want.x) report_mismatch("x_pos", out_x_pos, want.x);
          if (out_y_pos !== want.y) report_mismatch("y_pos", out_y_pos, want.y);
          if (out_z_pos !== want.z) report_mismatch("z_pos", out_z_pos, want.z);
          if (out_last_out !== want.last)
            report_mismatch("last_out", 17'(out_last_out), 17'(want.last));
        end
      end
    end
  end

endmodule

>>> tb/tb_spherical_to_cartesian.sv
// ----------------------------------------------------------------------------
// tb_spherical_to_cartesian
// Drives directed and random detections into the converter with random gaps
// and output stalls, including a long output hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_spherical_to_cartesian;

  localparam int RANDOM_BEATS = 1630;
  localparam int CYCLE_LIMIT = 200000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [15:0]        in_range_q8;
  logic signed [13:0] in_elevation;
  logic signed [14:0] in_azimuth;
  logic               in_last_in;
  logic               out_valid;
  logic               out_stall;
  logic signed [16:0] out_x_pos;
  logic signed [16:0] out_y_pos;
  logic signed [16:0] out_z_pos;
  logic               out_last_out;
  int                 errors;
  int                 pending;
  int                 cycles;
  logic               burst;

  spherical_to_cartesian u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_range_q8(in_range_q8), .in_elevation(in_elevation),
    .in_azimuth(in_azimuth), .in_last_in(in_last_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x_pos(out_x_pos), .out_y_pos(out_y_pos),
    .out_z_pos(out_z_pos), .out_last_out(out_last_out)
  );

  s2c_point_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_range_q8(in_range_q8), .in_elevation(in_elevation),
    .in_azimuth(in_azimuth), .in_last_in(in_last_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x_pos(out_x_pos), .out_y_pos(out_y_pos),
    .out_z_pos(out_z_pos), .out_last_out(out_last_out),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    burst = 0;
    in_valid = 0;
    in_range_q8 = '0;
    in_elevation = '0;
    in_azimuth = '0;
    in_last_in = 0;
    out_stall = 0;
    rst_n = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL spherical_to_cartesian");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off, no random stalls while the sender bursts
  always @(posedge clk) begin
    if (cycles >= 1500 && cycles < 1800)
      out_stall <= 1;
    else if (burst)
      out_stall <= 0;
    else
      out_stall <= ($urandom_range(99) < 34);
  end

  task automatic send_beat(logic [15:0] rng, logic [13:0] elev, logic [14:0] azim,
                           logic last, bit may_idle);
    bit taken;
    while (may_idle && $urandom_range(99) < 34) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_range_q8 <= rng;
    in_elevation <= elev;
    in_azimuth <= azim;
    in_last_in <= last;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  initial begin
    logic [13:0] elev;
    logic [14:0] azim;
    logic [15:0] rng;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // range and angle extremes, octant boundaries and out-of-range wraps
    send_beat(16'd0, 14'sd0, 15'sd0, 1'b0, 1);
    send_beat(16'hffff, 14'sd0, 15'sd0, 1'b1, 1);
    send_beat(16'hffff, 14'sd5760, 15'sd0, 1'b0, 1);
    send_beat(16'hffff, -14'sd5760, 15'sd11520, 1'b0, 1);
    send_beat(16'hffff, 14'sd2880, -15'sd11520, 1'b1, 1);
    send_beat(16'hffff, -14'sd2880, 15'sd5760, 1'b0, 1);
    send_beat(16'hffff, 14'sd0, -15'sd5760, 1'b0, 1);
    send_beat(16'h8000, 14'sd2881, 15'sd2879, 1'b0, 1);
    send_beat(16'h0001, 14'sd1, 15'sd1, 1'b1, 1);
    send_beat(16'h7fff, -14'sd1, -15'sd1, 1'b0, 1);
    send_beat(16'hffff, 14'sd8191, 15'sd16383, 1'b0, 1);
    send_beat(16'hffff, 14'h2000, 15'h4000, 1'b1, 1);
    send_beat(16'h1234, 14'sd8191, 15'h4000, 1'b0, 1);
    send_beat(16'hffff, 14'sd5000, 15'sd12000, 1'b0, 1);
    send_beat(16'hffff, -14'sd7000, 15'sd8640, 1'b1, 1);
    send_beat(16'h0100, 14'sd3000, -15'sd3000, 1'b0, 1);
    send_beat(16'hfffe, 14'sd64, 15'sd8640 + 15'sd1, 1'b1, 1);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if ($urandom_range(9) < 7) begin
        rng = 16'($urandom_range(65535));
        elev = 14'($urandom_range(11520) - 5760);
        azim = 15'($urandom_range(23040) - 11520);
      end else begin
        rng = 16'($urandom);
        elev = 14'($urandom);
        azim = 15'($urandom);
      end
      // no gaps on either side in the middle stretch
      burst <= (i >= 600 && i < 900);
      send_beat(rng, elev, azim, 1'($urandom_range(7) == 0), !(i >= 600 && i < 900));
    end
    in_valid <= 0;
    burst <= 0;

    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0)
      $display("PASS spherical_to_cartesian");
    else
      $display("FAIL spherical_to_cartesian");
    $finish;
  end

endmodule
